### hw/rtl/mipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mipd_pkg
// shared types and constants of the monochrome icon plane decoder
// ----------------------------------------------------------------------------
package mipd_pkg;

    localparam int HDR_BYTES = 14;
    localparam int WIN_BYTES = 18;
    localparam int DIM_LIMIT = 4096;

    // configuration register indexes
    localparam logic [1:0] CFG_EXP_FIG = 2'd0;
    localparam logic [1:0] CFG_CURSOR  = 2'd1;
    localparam logic [1:0] CFG_ICON    = 2'd2;
    localparam logic [1:0] CFG_MAX_DIM = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADHDR = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;
    localparam logic [1:0] ST_BIG    = 2'd3;

    // pixel colors
    localparam logic [1:0] COL_BLACK = 2'd0;
    localparam logic [1:0] COL_WHITE = 2'd1;
    localparam logic [1:0] COL_TRANS = 2'd2;
    localparam logic [1:0] COL_GRAY  = 2'd3;

    // one xor byte handed from the front end to the pixel emitter
    typedef struct packed {
        logic        has_byte;  // xor byte present with columns below 4096
        logic [7:0]  xor_byte;
        logic [11:0] col_base;  // column of the msb
        logic [11:0] row;
        logic [12:0] width_m;   // image width, 1 to 4096
        logic        has_stat;
        logic [1:0]  stat;
    } t_job;

endpackage

`default_nettype wire

### hw/rtl/mipd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mipd_ram
// single-port-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module mipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/mipd_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mipd_emit
// expands one xor byte and its and-mask byte into pixel items, then status if any
// ----------------------------------------------------------------------------
module mipd_emit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    output logic                 o_job_ready,
    input  mipd_pkg::t_job       i_job,
    input  wire  [7:0]           i_mask,     // valid in the cycle after accept
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [31:0]          o_data      // last, color, x, y, status, zeros, kind
);
    import mipd_pkg::*;

    logic        r_busy, r_first;
    t_job        r_job;
    logic [7:0]  r_mask;
    logic [3:0]  r_bit;      // next bit, 8 means status stage
    logic        r_ov;
    logic [31:0] r_od;

    logic [7:0]  w_mask;
    logic [11:0] w_x;
    logic        w_pix_here, w_more_pix, w_out_free, w_emit, w_done;
    logic        w_put, w_step, w_take;
    logic [7:0]  w_rest;
    logic [1:0]  w_col;
    logic        w_a, w_b, w_lastr;
    logic [2:0]  w_sh;

    assign w_mask = r_first ? i_mask : r_mask;
    assign w_sh   = 3'd7 - r_bit[2:0];
    assign w_x    = r_job.col_base + {9'd0, r_bit[2:0]};
    assign w_a    = w_mask[w_sh];
    assign w_b    = r_job.xor_byte[w_sh];
    assign w_pix_here = r_job.has_byte && !r_bit[3] && ({1'b0, w_x} < r_job.width_m);
    assign w_out_free = !r_ov || i_ready;

    // remaining visible pixels after this bit
    always_comb begin
        w_rest = 8'd0;
        for (int k = 0; k < 8; k++) begin
            w_rest[k] = (k > int'(r_bit[2:0])) && !r_bit[3] && r_job.has_byte &&
                        (({1'b0, r_job.col_base} + 13'(k)) < r_job.width_m);
        end
    end
    assign w_more_pix = |w_rest;
    assign w_lastr = !w_more_pix && !r_job.has_stat;

    always_comb begin
        case ({w_a, w_b})
            2'b00:   w_col = COL_BLACK;
            2'b01:   w_col = COL_WHITE;
            2'b10:   w_col = COL_TRANS;
            default: w_col = COL_GRAY;
        endcase
    end

    assign w_emit = r_busy && w_out_free && (r_bit[3] ? r_job.has_stat : 1'b1);
    assign w_put  = w_emit && (r_bit[3] || w_pix_here);
    assign w_step = r_busy && w_out_free && !r_bit[3];
    // job finishes when nothing is left after the current step
    assign w_done = r_busy && w_out_free &&
                    (r_bit[3] || (!w_more_pix && !r_job.has_stat));
    assign o_job_ready = !r_busy || w_done;
    assign w_take = i_job_valid && o_job_ready;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_first <= 1'b0;
            r_ov <= 1'b0;
            r_bit <= 4'd0;
        end else begin
            r_ov <= (r_ov && !i_ready) || w_put;
            if (w_put) begin
                r_od <= r_bit[3] ? {1'b1, 2'd0, r_job.stat, 24'd0, COL_BLACK, 1'b1}
                                 : {1'b0, 2'd0, ST_OK, r_job.row, w_x, w_col, w_lastr};
            end
            if (r_first) r_mask <= i_mask;
            if (w_take) begin
                r_busy <= 1'b1;
                r_first <= 1'b1;
                r_job <= i_job;
                r_bit <= i_job.has_byte ? 4'd0 : 4'd8;
            end else begin
                r_first <= 1'b0;
                if (w_done) r_busy <= 1'b0;
                if (w_step) r_bit <= w_more_pix ? r_bit + 4'd1 : 4'd8;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

`default_nettype wire

### hw/rtl/mono_icon_plane_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_icon_plane_decoder
// streams an and/xor monochrome icon resource into pixel and status items
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata[7:0] data_byte, tlast last_byte
// m_axis    out  tdata[27:0] color,pixel_x,pixel_y,status; tuser kind; tlast last
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data[12:0]
//
// header and and-plane bytes go one per cycle while the emitter is ready; an
// xor byte becomes one pixel item per visible pixel, plus a status item on
// the last byte. the and plane lives in a one-read one-write ram; the mask
// byte is read while the byte is handed to the emitter. reset is synchronous;
// a stalled output holds the emitter, which holds the input through tready.
// ----------------------------------------------------------------------------
module mono_icon_plane_decoder #(
    parameter int MASK_STORE_BYTES = 8192
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // color, pixel_x, pixel_y, status, zeros
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [12:0] i_cfg_data
);
    import mipd_pkg::*;

    localparam int AW = $clog2(MASK_STORE_BYTES);

    typedef enum logic [2:0] {PH_HDR, PH_AND, PH_XOR, PH_DONE, PH_DRAIN} t_ph;

    logic [7:0]  r_exp, r_cur, r_ico;
    logic [12:0] r_maxd;
    logic [7:0]  r_win [WIN_BYTES];
    logic [4:0]  r_hcnt;
    t_ph         r_ph;
    logic [AW:0] r_cnt, r_plane;
    logic [15:0] r_w, r_s;
    logic [15:0] r_col;
    logic [11:0] r_row;
    logic [1:0]  r_fault;

    logic [31:0] w_ed;
    logic        w_acc, w_jready;
    t_job        w_job;
    logic [7:0]  w_rd;
    logic [7:0]  w_win [WIN_BYTES];
    logic [12:0] w_lim;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = w_jready;
    assign w_lim = (r_maxd > 13'(DIM_LIMIT)) ? 13'(DIM_LIMIT) : r_maxd;

    // window with the incoming byte placed
    always_comb begin
        for (int k = 0; k < WIN_BYTES; k++) begin
            w_win[k] = (r_hcnt == 5'(k)) ? s_axis_tdata : r_win[k];
        end
    end

    function automatic logic hdr_ok(input logic [7:0] f, input logic [7:0] ind,
                                    input logic [15:0] w, input logic [15:0] h,
                                    input logic [15:0] s, input logic [15:0] p,
                                    input logic [7:0] cur, input logic [7:0] ico,
                                    input logic [7:0] ex, input logic [12:0] lim);
        logic ok;
        ok = (f == cur || f == ico) && (ex == 8'd0 || f == ex) && ind <= 8'd1;
        ok = ok && w != 16'd0 && h != 16'd0 && w <= {3'd0, lim} && h <= {3'd0, lim};
        ok = ok && s != 16'd0 && p == 16'd0 && !s[0];
        ok = ok && ({1'b0, s} >= ({1'b0, w} + 17'd7) >> 3);
        return ok;
    endfunction

    logic [15:0] w_w0, w_h0, w_s0, w_w4, w_h4, w_s4;
    logic        w_ok0, w_ok4, w_big0, w_big4;
    logic [31:0] w_pl0, w_pl4;
    assign w_w0 = {w_win[7], w_win[6]};
    assign w_h0 = {w_win[9], w_win[8]};
    assign w_s0 = {w_win[11], w_win[10]};
    assign w_w4 = {w_win[11], w_win[10]};
    assign w_h4 = {w_win[13], w_win[12]};
    assign w_s4 = {w_win[15], w_win[14]};
    assign w_ok0 = hdr_ok(w_win[0], w_win[1], w_w0, w_h0, w_s0, {w_win[13], w_win[12]},
                          r_cur, r_ico, r_exp, w_lim);
    assign w_ok4 = hdr_ok(w_win[4], w_win[5], w_w4, w_h4, w_s4, {w_win[17], w_win[16]},
                          r_cur, r_ico, r_exp, w_lim);
    assign w_pl0 = w_s0 * w_h0;
    assign w_pl4 = w_s4 * w_h4;
    assign w_big0 = w_pl0 > MASK_STORE_BYTES;
    assign w_big4 = w_pl4 > MASK_STORE_BYTES;

    // job to the emitter for every accepted byte that gives results
    always_comb begin
        w_job.has_byte = (r_ph == PH_XOR) && (r_col < 16'd512);
        w_job.xor_byte = s_axis_tdata;
        w_job.col_base = {r_col[8:0], 3'd0};
        w_job.row      = r_row;
        w_job.width_m  = r_w[12:0];
        w_job.has_stat = s_axis_tlast;
        if (r_fault != ST_OK) w_job.stat = r_fault;
        else if (r_ph == PH_HDR) begin
            // a header decided on this byte moves on to the and plane, or to drain if too big
            if (r_hcnt == 5'(HDR_BYTES - 1) && w_ok0)
                w_job.stat = w_big0 ? ST_BIG : ST_TRUNC;
            else if (r_hcnt == 5'(WIN_BYTES - 1))
                w_job.stat = !w_ok4 ? ST_BADHDR : (w_big4 ? ST_BIG : ST_TRUNC);
            else
                w_job.stat = ST_BADHDR;
        end
        else if (r_ph == PH_AND) w_job.stat = ST_TRUNC;
        else if (r_ph == PH_XOR) w_job.stat = (r_cnt + 1'b1 >= r_plane) ? ST_OK : ST_TRUNC;
        else w_job.stat = ST_OK;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= 8'd0; r_cur <= 8'd3; r_ico <= 8'd1; r_maxd <= 13'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXP_FIG: r_exp  <= i_cfg_data[7:0];
                CFG_CURSOR:  r_cur  <= i_cfg_data[7:0];
                CFG_ICON:    r_ico  <= i_cfg_data[7:0];
                CFG_MAX_DIM: r_maxd <= i_cfg_data;
                default:     r_exp  <= r_exp;
            endcase
        end
    end

    // front-end phase control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_HDR; r_hcnt <= 5'd0; r_cnt <= '0; r_fault <= ST_OK;
            r_col <= 16'd0; r_row <= 12'd0; r_w <= 16'd0; r_s <= 16'd0;
            r_plane <= '0;
            for (int k = 0; k < WIN_BYTES; k++) r_win[k] <= 8'd0;
        end else if (w_acc) begin
            if (s_axis_tlast) begin
                r_ph <= PH_HDR; r_hcnt <= 5'd0; r_cnt <= '0; r_fault <= ST_OK;
                r_col <= 16'd0; r_row <= 12'd0; r_w <= 16'd0; r_s <= 16'd0;
                r_plane <= '0;
                for (int k = 0; k < WIN_BYTES; k++) r_win[k] <= 8'd0;
            end else begin
                case (r_ph)
                    PH_HDR: begin
                        r_win <= w_win;
                        r_hcnt <= r_hcnt + 5'd1;
                        if (r_hcnt == 5'(HDR_BYTES - 1) && w_ok0) begin
                            r_w <= w_w0; r_s <= w_s0;
                            r_plane <= w_big0 ? '0 : (AW+1)'(w_pl0);
                            r_ph <= w_big0 ? PH_DRAIN : PH_AND;
                            r_fault <= w_big0 ? ST_BIG : ST_OK;
                        end else if (r_hcnt == 5'(WIN_BYTES - 1)) begin
                            r_w <= w_w4; r_s <= w_s4;
                            r_plane <= w_big4 ? '0 : (AW+1)'(w_pl4);
                            r_ph <= !w_ok4 ? PH_DRAIN : (w_big4 ? PH_DRAIN : PH_AND);
                            r_fault <= !w_ok4 ? ST_BADHDR : (w_big4 ? ST_BIG : ST_OK);
                        end
                    end
                    PH_AND: begin
                        if (r_cnt + 1'b1 >= r_plane) begin
                            r_ph <= PH_XOR; r_cnt <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    PH_XOR: begin
                        if (r_col + 16'd1 >= r_s) begin
                            r_col <= 16'd0; r_row <= r_row + 12'd1;
                        end else begin
                            r_col <= r_col + 16'd1;
                        end
                        if (r_cnt + 1'b1 >= r_plane) begin
                            r_ph <= PH_DONE; r_cnt <= '0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    default: r_ph <= r_ph;
                endcase
            end
        end
    end

    mipd_ram #(.WIDTH(8), .DEPTH(MASK_STORE_BYTES)) u_mask (
        .i_clk   (i_clk),
        .i_we    (w_acc && r_ph == PH_AND),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rd)
    );

    mipd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (s_axis_tvalid && (r_ph == PH_XOR || s_axis_tlast)),
        .o_job_ready (w_jready),
        .i_job       (w_job),
        .i_mask      (w_rd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_ed)
    );

    assign m_axis_tlast = w_ed[0];
    assign m_axis_tdata = {4'd0, w_ed[28:1]};
    assign m_axis_tuser = w_ed[31];

    // a status item always closes its input byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("status not last");
    // in the and phase the mask count stays below the plane size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == PH_AND |-> r_cnt < r_plane) else $error("and count overrun");
    // pixel items carry ok status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[27:26] == ST_OK)
        else $error("pixel with status");

endmodule

`default_nettype wire
